@@ rtl/mlst_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the max line segment tree.
// No dependencies; imported by the top, mlst_eval and mlst_walk, not by mlst_ram.
package mlst_pkg;

	// default depth of the point range, in bits
	localparam int DOMAIN_BITS_DEF = 16;

	// reset value of the range register
	localparam logic [15:0] DOMAIN_HIGH_RST = 16'hFFFF;

	// width of the clear epoch mark kept with every node
	localparam int EPOCH_W = 4;

	// sign bit of a 64-bit word; also the bias that makes unsigned compares signed
	localparam logic [63:0] SIGN64 = 64'h8000_0000_0000_0000;

	// operation codes carried by each input word
	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_QUERY  = 2'd1,
		MODE_CLEAR  = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	// one line y = slope * x + intercept
	typedef struct packed {
		logic [31:0] slope;
		logic [63:0] intercept;
	} line_t;

	// biased line values at the three points of a node
	typedef struct packed {
		logic [63:0] new_lo;
		logic [63:0] new_hi;
		logic [63:0] new_mid;
		logic [63:0] node_lo;
		logic [63:0] node_hi;
		logic [63:0] node_mid;
	} line_vals_t;

	// finished query word handed to the output register
	typedef struct packed {
		logic        valid;
		logic [63:0] value;
	} result_t;

endpackage

@@ rtl/max_line_segment_tree.sv @@
`timescale 1ns / 1ps
// Max line segment tree: each node visit is a read, a multiply and an add/decide.
// Insert and query visit one node per tree level, up to DOMAIN_BITS+1 levels; a query
// then hands over its result, waiting while the output side stalls. The node RAM read
// and the evaluator's two stages set the steps of each level.
// A clear advances the epoch, except every fifteenth, which sweeps 2^(DOMAIN_BITS+1) tags.
// After reset the same tag sweep runs with in_stall high.
module max_line_segment_tree #(
	parameter int DOMAIN_BITS = mlst_pkg::DOMAIN_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [15:0]         cfg_wr_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          mode,
	input  logic signed [31:0]  slope,
	input  logic signed [63:0]  intercept,
	input  logic [15:0]         point_x,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [63:0]  max_value
);
	import mlst_pkg::*;

	localparam int POINT_W = ((DOMAIN_BITS > 16) ? DOMAIN_BITS : 16) + 1;
	localparam logic [POINT_W-1:0] POINT_CAP = POINT_W'((1 << DOMAIN_BITS) - 1);

	logic [15:0]         domain_high_q;
	logic [POINT_W-1:0]  top_point;
	result_t             res;
	logic                out_free;
	logic                out_valid_q;
	logic [63:0]         max_value_q;

	// range register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			domain_high_q <= DOMAIN_HIGH_RST;
		end else if (cfg_wr_en) begin
			domain_high_q <= cfg_wr_data;
		end
	end

	// saturate the range to the tree depth
	assign top_point = (POINT_W'(domain_high_q) > POINT_CAP) ? POINT_CAP :
		POINT_W'(domain_high_q);

	mlst_walk #(
		.DOMAIN_BITS (DOMAIN_BITS),
		.POINT_W     (POINT_W)
	) u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.slope     (slope),
		.intercept (intercept),
		.point_x   (point_x),
		.top_point (top_point),
		.res       (res),
		.res_free  (out_free)
	);

	// output word register
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid && out_free) begin
			max_value_q <= res.value;
		end
	end

	assign out_valid = out_valid_q;
	assign max_value = max_value_q;

	// a walk keeps the input side closed while it runs
	a_walk_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && (mode == MODE_INSERT || mode == MODE_QUERY))
		|=> in_stall)
		else $error("input accepted while a walk was starting");

	// a new result word only appears after a query walk
	a_word_from_walk: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result word without a running query");

	// an insert leaves the output side untouched
	a_insert_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && mode == MODE_INSERT) |=> !$rose(out_valid))
		else $error("insert produced a result word");

endmodule

@@ rtl/mlst_ram.sv @@
`timescale 1ns / 1ps
// Simple dual-port synchronous RAM: one write port, one registered read port.
// No dependencies.
module mlst_ram #(
	parameter int ADDR_W = 17,
	parameter int DATA_W = 96
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];
	logic [DATA_W-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port; hold the word until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/mlst_eval.sv @@
`timescale 1ns / 1ps
// Two-stage line evaluator: the carried line and the node line at lo, hi and mid.
// Depends on mlst_pkg.
module mlst_eval #(
	parameter int POINT_W = 17
) (
	input  logic                    clk,
	input  mlst_pkg::line_t         new_line,
	input  mlst_pkg::line_t         node_raw,
	input  logic                    node_used,
	input  logic [POINT_W-1:0]      p_lo,
	input  logic [POINT_W-1:0]      p_hi,
	input  logic [POINT_W-1:0]      p_mid,
	output mlst_pkg::line_t         node_line,
	output mlst_pkg::line_vals_t    vals
);
	import mlst_pkg::*;

	localparam int PROD_W = 33 + POINT_W;

	logic signed [PROD_W-1:0] nl_s1, nh_s1, nm_s1;
	logic signed [PROD_W-1:0] ol_s1, oh_s1, om_s1;
	line_t                    node_g;
	line_t                    node_s1;
	line_vals_t               vals_s2;

	// wrap the sum at 64 bits and bias it for unsigned ordering
	function automatic logic [63:0] biased(input logic signed [PROD_W-1:0] p,
			input logic [63:0] c);
		return (64'(p) + c) ^ SIGN64;
	endfunction

	// an unused node acts as the flat line at the 64-bit minimum
	always_comb begin
		node_g = node_used ? node_raw : '{slope: 32'd0, intercept: SIGN64};
	end

	// stage 1: slope times point
	always_ff @(posedge clk) begin
		nl_s1   <= PROD_W'($signed(new_line.slope)) * PROD_W'($signed({1'b0, p_lo}));
		nh_s1   <= PROD_W'($signed(new_line.slope)) * PROD_W'($signed({1'b0, p_hi}));
		nm_s1   <= PROD_W'($signed(new_line.slope)) * PROD_W'($signed({1'b0, p_mid}));
		ol_s1   <= PROD_W'($signed(node_g.slope)) * PROD_W'($signed({1'b0, p_lo}));
		oh_s1   <= PROD_W'($signed(node_g.slope)) * PROD_W'($signed({1'b0, p_hi}));
		om_s1   <= PROD_W'($signed(node_g.slope)) * PROD_W'($signed({1'b0, p_mid}));
		node_s1 <= node_g;
	end

	// stage 2: add the intercepts
	always_ff @(posedge clk) begin
		vals_s2.new_lo   <= biased(nl_s1, new_line.intercept);
		vals_s2.new_hi   <= biased(nh_s1, new_line.intercept);
		vals_s2.new_mid  <= biased(nm_s1, new_line.intercept);
		vals_s2.node_lo  <= biased(ol_s1, node_s1.intercept);
		vals_s2.node_hi  <= biased(oh_s1, node_s1.intercept);
		vals_s2.node_mid <= biased(om_s1, node_s1.intercept);
	end

	assign node_line = node_s1;
	assign vals      = vals_s2;

endmodule

@@ rtl/mlst_walk.sv @@
`timescale 1ns / 1ps
// Tree walker: node memories, epoch clear, insert and query descent sequencer.
// Depends on mlst_pkg, mlst_ram and mlst_eval.
module mlst_walk #(
	parameter int DOMAIN_BITS = 16,
	parameter int POINT_W     = 17
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           mode,
	input  logic signed [31:0]   slope,
	input  logic signed [63:0]   intercept,
	input  logic [15:0]          point_x,
	input  logic [POINT_W-1:0]   top_point,
	output mlst_pkg::result_t    res,
	input  logic                 res_free
);
	import mlst_pkg::*;

	localparam int ADDR_W = DOMAIN_BITS + 1;
	localparam int LINE_W = $bits(line_t);
	localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
	localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

	typedef enum logic [5:0] {
		S_SWEEP = 6'b000001,
		S_IDLE  = 6'b000010,
		S_MUL   = 6'b000100,
		S_ADD   = 6'b001000,
		S_DEC   = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t              state_q;
	logic [EPOCH_W-1:0]  epoch_q;
	logic [ADDR_W-1:0]   sweep_q;
	logic                query_q;
	logic [ADDR_W-1:0]   idx_q;
	logic [POINT_W-1:0]  lo_q, hi_q, mid_q, x_q;
	line_t               line_q;
	logic [63:0]         best_q;

	// memory ports
	logic                rd_en;
	logic [ADDR_W-1:0]   rd_addr;
	logic [LINE_W-1:0]   line_rd;
	logic [EPOCH_W-1:0]  tag_rd;
	logic                line_we, tag_we;
	logic [ADDR_W-1:0]   tag_waddr;
	logic [EPOCH_W-1:0]  tag_wdata;
	logic                node_used;
	line_t               node_raw, node_line, node_wr, carried;
	line_vals_t          vals;

	// decision signals
	logic                start;
	logic                nge_l, nge_h, nge_m, oge_l, oge_h, oge_m;
	logic                swap1, kgp_l, kgp_h, stop, a_is_new, go_left;
	logic                node_is_new, go_right, cont;
	logic [ADDR_W:0]     child;
	logic                child_ovf;
	logic [POINT_W-1:0]  lo_n, hi_n, mid_n;
	logic [POINT_W:0]    mid_sum;
	logic [63:0]         best_n;

	assign in_stall  = (state_q != S_IDLE);
	assign start     = (state_q == S_IDLE) && in_valid &&
		(mode == MODE_INSERT || mode == MODE_QUERY);
	assign node_used = (tag_rd == epoch_q);
	assign node_raw  = line_t'(line_rd);

	mlst_ram #(
		.ADDR_W (ADDR_W),
		.DATA_W (LINE_W)
	) u_line_ram (
		.clk   (clk),
		.we    (line_we),
		.waddr (idx_q),
		.wdata (LINE_W'(node_wr)),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (line_rd)
	);

	mlst_ram #(
		.ADDR_W (ADDR_W),
		.DATA_W (EPOCH_W)
	) u_tag_ram (
		.clk   (clk),
		.we    (tag_we),
		.waddr (tag_waddr),
		.wdata (tag_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (tag_rd)
	);

	mlst_eval #(
		.POINT_W (POINT_W)
	) u_eval (
		.clk       (clk),
		.new_line  (line_q),
		.node_raw  (node_raw),
		.node_used (node_used),
		.p_lo      (query_q ? x_q : lo_q),
		.p_hi      (hi_q),
		.p_mid     (mid_q),
		.node_line (node_line),
		.vals      (vals)
	);

	// pairwise compares; the insert choices below are plain logic on these
	always_comb begin
		nge_l = vals.new_lo  >= vals.node_lo;
		nge_h = vals.new_hi  >= vals.node_hi;
		nge_m = vals.new_mid >= vals.node_mid;
		oge_l = vals.node_lo  >= vals.new_lo;
		oge_h = vals.node_hi  >= vals.new_hi;
		oge_m = vals.node_mid >= vals.new_mid;

		// carried line takes the node when it wins at both ends
		swap1 = nge_l & nge_h;
		kgp_l = swap1 ? nge_l : oge_l;
		kgp_h = swap1 ? nge_h : oge_h;
		stop  = kgp_l & kgp_h;
		// A is the line at least as high at lo, B the other one
		a_is_new = swap1 ^ ~kgp_l;
		go_left  = a_is_new ? oge_m : nge_m;
		if (stop) begin
			node_is_new = swap1;
		end else begin
			node_is_new = go_left ? ~a_is_new : a_is_new;
		end
		node_wr = node_is_new ? line_q : node_line;
		carried = node_is_new ? node_line : line_q;

		// next node and its range
		go_right  = query_q ? (x_q > mid_q) : ~go_left;
		child     = {idx_q, go_right};
		child_ovf = idx_q[ADDR_W-1];
		lo_n      = go_right ? (mid_q + 1'b1) : lo_q;
		hi_n      = go_right ? hi_q : mid_q;
		mid_sum   = {1'b0, lo_n} + {1'b0, hi_n};
		mid_n     = mid_sum[POINT_W:1];
		best_n    = (vals.node_lo > best_q) ? vals.node_lo : best_q;
		cont      = query_q ? ~child_ovf : (~stop & ~child_ovf);
	end

	// memory port control
	always_comb begin
		rd_en     = 1'b0;
		rd_addr   = ADDR_W'(1);
		line_we   = 1'b0;
		tag_we    = 1'b0;
		tag_waddr = idx_q;
		tag_wdata = epoch_q;
		case (state_q)
			S_SWEEP: begin
				tag_we    = 1'b1;
				tag_waddr = sweep_q;
				tag_wdata = '0;
			end
			S_IDLE: begin
				rd_en = start;
			end
			S_DEC: begin
				rd_en   = cont;
				rd_addr = child[ADDR_W-1:0];
				line_we = ~query_q;
				tag_we  = ~query_q;
			end
			default: begin
			end
		endcase
	end

	// sequencer and epoch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SWEEP;
			epoch_q <= EPOCH_FIRST;
			sweep_q <= '0;
			query_q <= 1'b0;
		end else begin
			case (state_q)
				S_SWEEP: begin
					sweep_q <= sweep_q + 1'b1;
					if (&sweep_q) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						case (mode_t'(mode))
							MODE_INSERT, MODE_QUERY: begin
								query_q <= (mode == MODE_QUERY);
								state_q <= S_MUL;
							end
							MODE_CLEAR: begin
								// advance the epoch; sweep the tags when it runs out
								if (epoch_q == EPOCH_LAST) begin
									epoch_q <= EPOCH_FIRST;
									sweep_q <= '0;
									state_q <= S_SWEEP;
								end else begin
									epoch_q <= epoch_q + 1'b1;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_MUL: begin
					if (query_q && !node_used) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_ADD;
					end
				end
				S_ADD: begin
					state_q <= S_DEC;
				end
				S_DEC: begin
					if (cont) begin
						state_q <= S_MUL;
					end else if (query_q) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_DONE: begin
					if (res_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// walk payload: node index, range, carried line, best value
	always_ff @(posedge clk) begin
		if (start) begin
			idx_q  <= ADDR_W'(1);
			lo_q   <= '0;
			hi_q   <= top_point;
			mid_q  <= top_point >> 1;
			x_q    <= POINT_W'(point_x);
			line_q <= '{slope: slope, intercept: intercept};
			best_q <= '0;
		end else if (state_q == S_DEC) begin
			idx_q  <= child[ADDR_W-1:0];
			lo_q   <= lo_n;
			hi_q   <= hi_n;
			mid_q  <= mid_n;
			best_q <= best_n;
			if (!query_q) begin
				line_q <= carried;
			end
		end
	end

	assign res.valid = (state_q == S_DONE);
	assign res.value = best_q ^ SIGN64;

endmodule
